// ----- hdl/two_stack_queue_defines.svh -----
// Assertion macros shared by the two-stack queue checker.
`ifndef TWO_STACK_QUEUE_DEFINES_SVH
`define TWO_STACK_QUEUE_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock and off during reset.
`define TSQ_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on the rising clock and off during reset.
`define TSQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/tsq_pkg.sv -----
// Shared constants for the two-stack queue: request kinds, result widths and state codes.
package tsq_pkg;

  // Request kinds.
  localparam logic KIND_PUSH = 1'b0;
  localparam logic KIND_POP  = 1'b1;

  // Fixed widths of the request and result fields.
  localparam int PUSH_WIDTH   = 32;
  localparam int RESULT_WIDTH = 32;
  localparam int OPS_WIDTH    = 12;

  // Controller state codes.
  localparam int STATE_W = 2;
  localparam logic [STATE_W-1:0] ST_IDLE     = 2'd0;
  localparam logic [STATE_W-1:0] ST_MOVE     = 2'd1;
  localparam logic [STATE_W-1:0] ST_POP_READ = 2'd2;

endpackage

// ----- hdl/tsq_stack_ram.sv -----
// Stack storage: a single-port-write, single-port-read synchronous RAM with registered read data.
module tsq_stack_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hdl/two_stack_queue.sv -----
// Top level of the two-stack FIFO queue: controller plus the input and output stack RAMs.
//
// Usage: a request is taken at a rising edge where start is high and busy is low.
// kind selects push (store push_value) or pop (remove the oldest value).
// A push gives no result; a push onto a full input stack is dropped.
// Every pop gives exactly one result: done is high for one cycle with pop_value,
// stack_op_count (2*moved+1, low 12 bits) and empty_error.
// A pop on an empty queue gives empty_error = 1 with value and count zero in the cycle
// after the request, and busy stays low.
// A pop with a filled output stack reads its top: busy for one cycle, and the result
// is registered from the output RAM read data.
// A pop with an empty output stack first moves the n entries of the input stack over,
// one per cycle through the input RAM read port feeding the output RAM write port;
// then the top of the output stack is read out as for a filled output stack.
// Over a stream, each value is moved once.
// The result ports cannot be held off; done lasts one cycle, and a new request can be
// taken in the same cycle that a result is shown.
// Reset empties both stacks and clears done and busy; RAM contents are not cleared
// and need no clearing pass, since only entries below the counts are ever read.
module two_stack_queue #(
  parameter int STACK_DEPTH = 1024,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 kind,
  input  logic signed [tsq_pkg::PUSH_WIDTH-1:0]   push_value,
  output logic                                 done,
  output logic signed [tsq_pkg::RESULT_WIDTH-1:0] pop_value,
  output logic        [tsq_pkg::OPS_WIDTH-1:0]    stack_op_count,
  output logic                                 empty_error
);
  import tsq_pkg::*;

  localparam int AW    = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CW    = $clog2(STACK_DEPTH + 1);
  localparam int OPS_W = (CW + 1 > OPS_WIDTH) ? CW + 1 : OPS_WIDTH;

  logic [STATE_W-1:0]     state;
  logic [CW-1:0]          in_cnt;
  logic [CW-1:0]          out_cnt;
  logic [CW-1:0]          moved;
  logic                   pending;

  logic                   accept;
  logic [CW-1:0]          in_cnt_m1;
  logic [CW-1:0]          out_cnt_m1;
  logic [OPS_W-1:0]       ops_full;

  logic                   in_we;
  logic [VALUE_WIDTH-1:0] in_wdata;
  logic                   in_re;
  logic [VALUE_WIDTH-1:0] in_rdata;
  logic                   out_we;
  logic                   pop_go;
  logic [VALUE_WIDTH-1:0] out_rdata;

  // Request handshake and stack pointers.
  assign busy       = (state != ST_IDLE);
  assign accept     = start && !busy;
  assign in_cnt_m1  = in_cnt - CW'(1);
  assign out_cnt_m1 = out_cnt - CW'(1);

  // Operation count is 2*moved+1, kept to the low bits of the result field.
  assign ops_full = OPS_W'({moved, 1'b1});

  // RAM port controls. The state machine keeps reads and writes of the same stack
  // apart in time, so no forwarding is needed.
  always_comb begin
    in_we    = accept && (kind == KIND_PUSH) && (in_cnt < CW'(STACK_DEPTH));
    in_wdata = VALUE_WIDTH'($unsigned(push_value));
    in_re    = (state == ST_MOVE) && (in_cnt != '0);
    out_we   = (state == ST_MOVE) && pending;
    pop_go   = (accept && (kind == KIND_POP) && (out_cnt != '0)) ||
               ((state == ST_MOVE) && (in_cnt == '0) && !pending);
  end

  tsq_stack_ram #(
    .DEPTH (STACK_DEPTH),
    .WIDTH (VALUE_WIDTH),
    .AW    (AW)
  ) u_in_stack (
    .clk   (clk),
    .we    (in_we),
    .waddr (in_cnt[AW-1:0]),
    .wdata (in_wdata),
    .re    (in_re),
    .raddr (in_cnt_m1[AW-1:0]),
    .rdata (in_rdata)
  );

  tsq_stack_ram #(
    .DEPTH (STACK_DEPTH),
    .WIDTH (VALUE_WIDTH),
    .AW    (AW)
  ) u_out_stack (
    .clk   (clk),
    .we    (out_we),
    .waddr (out_cnt[AW-1:0]),
    .wdata (in_rdata),
    .re    (pop_go),
    .raddr (out_cnt_m1[AW-1:0]),
    .rdata (out_rdata)
  );

  // Controller: push, empty pop, transfer loop and pop readout.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      in_cnt  <= '0;
      out_cnt <= '0;
      moved   <= '0;
      pending <= 1'b0;
      done    <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (kind == KIND_PUSH) begin
              if (in_we) begin
                in_cnt <= in_cnt + CW'(1);
              end
            end else if ((in_cnt == '0) && (out_cnt == '0)) begin
              done           <= 1'b1;
              empty_error    <= 1'b1;
              pop_value      <= '0;
              stack_op_count <= '0;
            end else if (out_cnt != '0) begin
              moved   <= '0;
              out_cnt <= out_cnt_m1;
              state   <= ST_POP_READ;
            end else begin
              moved   <= '0;
              pending <= 1'b0;
              state   <= ST_MOVE;
            end
          end
        end
        ST_MOVE: begin
          pending <= in_re;
          if (in_re) begin
            in_cnt <= in_cnt_m1;
          end
          if (out_we) begin
            out_cnt <= out_cnt + CW'(1);
            moved   <= moved + CW'(1);
          end
          if (pop_go) begin
            out_cnt <= out_cnt_m1;
            state   <= ST_POP_READ;
          end
        end
        ST_POP_READ: begin
          done           <= 1'b1;
          empty_error    <= 1'b0;
          pop_value      <= $signed(RESULT_WIDTH'(out_rdata));
          stack_op_count <= ops_full[OPS_WIDTH-1:0];
          state          <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// ----- hdl/tsq_checker.sv -----
// Port-level checker for the two-stack queue and its bind to the top level.
`include "two_stack_queue_defines.svh"

module tsq_checker (
  input logic                                 clk,
  input logic                                 rst,
  input logic                                 start,
  input logic                                 busy,
  input logic                                 kind,
  input logic                                 done,
  input logic signed [tsq_pkg::RESULT_WIDTH-1:0] pop_value,
  input logic        [tsq_pkg::OPS_WIDTH-1:0]    stack_op_count,
  input logic                                 empty_error
);
  import tsq_pkg::*;

  // An empty-queue result carries a zero value and a zero count.
  `TSQ_ASSERT_NOW(a_empty_zero, done && empty_error, (pop_value == '0) && (stack_op_count == '0), "empty pop result is not zero")

  // A successful pop always reports an odd operation count.
  `TSQ_ASSERT_NOW(a_ops_odd, done && !empty_error, stack_op_count[0] == 1'b1, "pop count is not odd")

  // A push request never produces a result.
  `TSQ_ASSERT_NEXT(a_push_silent, start && !busy && (kind == KIND_PUSH), !done, "push produced a result")

  // A pop request either answers at once or keeps the block busy.
  `TSQ_ASSERT_NEXT(a_pop_progress, start && !busy && (kind == KIND_POP), busy || done, "pop request was lost")

endmodule

bind two_stack_queue tsq_checker u_tsq_checker (.*);
